FILE: hw/rtl/rmet_pkg.sv
package rmet_pkg;

    localparam int FRAC_BITS = 40;
    localparam int FIX_W     = 64;
    localparam int ACC_W     = 130;
    localparam int MAG_W     = 128;
    localparam int QUO_BITS  = 63;
    localparam int CODE_W    = 11;

    typedef logic signed [FIX_W-1:0] t_fix;

    // configuration register indexes
    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_ESCAPE = 2'd1;
    localparam logic [1:0] CFG_ITER   = 2'd2;

    // product-sum operations
    localparam logic [2:0] OP_NORM = 3'd0;  // xr*xr + xi*xi
    localparam logic [2:0] OP_CRE  = 3'd1;  // pr*xr - pi*xi
    localparam logic [2:0] OP_CIM  = 3'd2;  // pr*xi + pi*xr
    localparam logic [2:0] OP_DEN  = 3'd3;  // mr*mr + pi*pi
    localparam logic [2:0] OP_NRE  = 3'd4;  // nr*mr + ni*pi
    localparam logic [2:0] OP_NIM  = 3'd5;  // ni*mr - nr*pi

    localparam t_fix ONE_FIX = 64'sh0000_0100_0000_0000;
    localparam t_fix SAT_RE  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_fix SAT_IM  = 64'sh8000_0000_0000_0000;

    localparam logic [CODE_W-1:0] CODE_BOUNDED = 11'h7FF;
    localparam logic [CODE_W-1:0] LOWER_OFFSET = 11'd21;

    typedef struct packed {
        logic       load;
        logic       init_p;
        logic       mac_go;
        logic [2:0] mac_op;
        logic       sub_go;
        logic       div_go;
        logic       upd_x;
    } t_dp_cmd;

    typedef struct packed {
        logic mac_done;
        logic mac_busy;
        logic div_done;
        logic norm_ge;
        logic flt;
        logic xi_pos;
    } t_dp_sts;

endpackage

FILE: hw/rtl/rational_map_escape_time.sv
// Channel   Direction  Payload (low bit up)
// s_axis    in         tdata: point_re[31:0], point_im[63:32]
// m_axis    out        tdata: escape_code[10:0], zero fill [15:11]
// cfg       in         index 0 degree, 1 escape_limit, 2 iteration_limit
//
// One point runs n map steps of degree d (d below 1 counts as 1); the run
// also ends when the magnitude bound is reached, and a step that faults
// is cut short. A 32x32 multiplier stepped over eight partial products per
// product sum and two one-bit-per-cycle dividers do the arithmetic.
// Synchronous active-low reset returns degree 3, escape_limit 100,
// iteration_limit 50 and drops any pending result.
// A new point is taken once the previous one is finished, even while its
// result waits in the output register; a stalled output stalls completion.
module rational_map_escape_time import rmet_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // point_re[31:0], point_im[63:32]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // escape_code[10:0], zeros[15:11]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [2:0]        r_degree;
    logic [6:0]        r_escape_limit;
    logic [7:0]        r_iter_limit;
    t_dp_cmd           dp_cmd;
    t_dp_sts           dp_sts;
    logic [CODE_W-1:0] code;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree       <= 3'd3;
            r_escape_limit <= 7'd100;
            r_iter_limit   <= 8'd50;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEGREE: r_degree       <= i_cfg_data[2:0];
                CFG_ESCAPE: r_escape_limit <= i_cfg_data[6:0];
                CFG_ITER:   r_iter_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    rmet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_code      (code),
        .i_degree    (r_degree),
        .i_iter_lim  (r_iter_limit),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    rmet_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_point_re     (i_s_axis_tdata[31:0]),
        .i_point_im     (i_s_axis_tdata[63:32]),
        .i_escape_limit (r_escape_limit),
        .o_sts          (dp_sts)
    );

    assign o_m_axis_tdata = {5'd0, code};

endmodule

FILE: hw/rtl/rmet_mac.sv
module rmet_mac import rmet_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_neg2,
    input  t_fix             i_a1,
    input  t_fix             i_b1,
    input  t_fix             i_a2,
    input  t_fix             i_b2,
    output logic             o_busy,
    output logic             o_done,
    output logic             o_neg,
    output logic [MAG_W-1:0] o_mag
);

    logic [FIX_W-1:0] r_ma1, r_mb1, r_ma2, r_mb2;
    logic             r_s1, r_s2;
    logic             r_busy, r_pv, r_fin, r_done;
    logic [3:0]       r_step;
    logic [FIX_W-1:0] r_pp;
    logic [1:0]       r_psh;
    logic             r_pneg;
    logic [ACC_W-1:0] r_acc;
    logic [MAG_W-1:0] r_mag;
    logic             r_neg;

    logic [FIX_W-1:0] w_ma, w_mb;
    logic [31:0]      w_ha, w_hb;
    logic [ACC_W-1:0] w_term, w_acc_nx, w_acc_abs;

    function automatic logic [FIX_W-1:0] mag64(input t_fix v);
        mag64 = v[FIX_W-1] ? (64'd0 - v) : v;
    endfunction

    // partial product select: step bit 2 picks the term, bits 1:0 the halves
    assign w_ma = r_step[2] ? r_ma2 : r_ma1;
    assign w_mb = r_step[2] ? r_mb2 : r_mb1;
    assign w_ha = r_step[1] ? w_ma[63:32] : w_ma[31:0];
    assign w_hb = r_step[0] ? w_mb[63:32] : w_mb[31:0];

    // align and accumulate the registered partial product
    always_comb begin
        case (r_psh)
            2'd1:    w_term = {34'd0, r_pp, 32'd0};
            2'd2:    w_term = {2'd0, r_pp, 64'd0};
            default: w_term = {66'd0, r_pp};
        endcase
        w_acc_nx  = r_acc + (w_term ^ {ACC_W{r_pneg}}) + {{(ACC_W-1){1'b0}}, r_pneg};
        w_acc_abs = r_acc[ACC_W-1] ? ({ACC_W{1'b0}} - r_acc) : r_acc;
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= 4'd0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_step <= 4'd0;
            end else if (r_busy) begin
                r_pv <= (r_step != 4'd8);
                if (r_step != 4'd8) begin
                    r_step <= r_step + 4'd1;
                end else begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // operands, products, accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma1 <= mag64(i_a1);
            r_mb1 <= mag64(i_b1);
            r_ma2 <= mag64(i_a2);
            r_mb2 <= mag64(i_b2);
            r_s1  <= i_a1[FIX_W-1] ^ i_b1[FIX_W-1];
            r_s2  <= i_a2[FIX_W-1] ^ i_b2[FIX_W-1] ^ i_neg2;
            r_acc <= '0;
        end else begin
            if (r_busy && r_step != 4'd8) begin
                r_pp   <= w_ha * w_hb;
                r_psh  <= {1'b0, r_step[1]} + {1'b0, r_step[0]};
                r_pneg <= r_step[2] ? r_s2 : r_s1;
            end
            if (r_busy && r_pv) begin
                r_acc <= w_acc_nx;
            end
        end
        if (r_fin) begin
            r_mag <= w_acc_abs[MAG_W-1:0];
            r_neg <= r_acc[ACC_W-1];
        end
    end

    assign o_busy = r_busy | r_fin;
    assign o_done = r_done;
    assign o_neg  = r_neg;
    assign o_mag  = r_mag;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy)
        else $error("product-sum restarted while busy");
`endif

endmodule

FILE: hw/rtl/rmet_div.sv
module rmet_div import rmet_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_neg,
    input  logic [MAG_W-1:0] i_num,
    input  logic [MAG_W-1:0] i_den,
    output logic             o_done,
    output logic             o_flt,
    output t_fix             o_q
);

    logic                r_busy, r_fin, r_done;
    logic [5:0]          r_cnt;
    logic [MAG_W-1:0]    r_rem, r_den;
    logic [QUO_BITS-1:0] r_lo, r_qm;
    logic                r_neg, r_flt;
    t_fix                r_q;

    logic [MAG_W:0]      w_t, w_d;
    logic                w_ge;
    logic                w_ovf;

    // quotient of |num|*2^40/den reaches 2^63 exactly when |num| >= den*2^23
    assign w_ovf = ({23'd0, i_num} >= {i_den, 23'd0});

    // one restoring step per cycle
    assign w_t  = {r_rem, r_lo[QUO_BITS-1]};
    assign w_ge = (w_t >= {1'b0, r_den});
    assign w_d  = w_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(QUO_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flt <= w_ovf;
            r_neg <= i_neg;
            r_den <= i_den;
            r_rem <= {23'd0, i_num[MAG_W-1:23]};
            r_lo  <= {i_num[22:0], 40'd0};
        end else if (r_busy) begin
            r_rem <= w_ge ? w_d[MAG_W-1:0] : w_t[MAG_W-1:0];
            r_lo  <= {r_lo[QUO_BITS-2:0], 1'b0};
            r_qm  <= {r_qm[QUO_BITS-2:0], w_ge};
        end
        if (r_fin) begin
            r_q <= r_neg ? (64'sd0 - t_fix'({1'b0, r_qm})) : t_fix'({1'b0, r_qm});
        end
    end

    assign o_done = r_done;
    assign o_flt  = r_flt;
    assign o_q    = r_q;

endmodule

FILE: hw/rtl/rmet_dp.sv
module rmet_dp import rmet_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic signed [31:0] i_point_re,
    input  logic signed [31:0] i_point_im,
    input  logic [6:0]         i_escape_limit,
    output t_dp_sts            o_sts
);

    t_fix             r_ar, r_ai, r_xr, r_xi, r_pr, r_pi, r_nr, r_ni, r_mr, r_tmp;
    logic [MAG_W-1:0] r_den, r_nre_mag, r_nim_mag;
    logic             r_nre_neg, r_nim_neg;
    logic [2:0]       r_op;
    logic             r_flt;

    t_fix             w_a1, w_b1, w_a2, w_b2;
    logic             w_neg2;
    logic             mac_done, mac_busy, mac_neg;
    logic [MAG_W-1:0] mac_mag;
    logic [FIX_W-1:0] w_sc_mag;
    t_fix             w_sc_val;
    logic             w_sc_flt;
    logic [FIX_W:0]   w_dnr, w_dni, w_dmr;
    logic             w_sub_ovf;
    logic             dre_done, dim_done, dre_flt, dim_flt;
    t_fix             dre_q, dim_q;

    // operand routing to the product-sum unit
    always_comb begin
        case (i_cmd.mac_op)
            OP_CRE:  begin w_a1 = r_pr; w_b1 = r_xr; w_a2 = r_pi; w_b2 = r_xi; w_neg2 = 1'b1; end
            OP_CIM:  begin w_a1 = r_pr; w_b1 = r_xi; w_a2 = r_pi; w_b2 = r_xr; w_neg2 = 1'b0; end
            OP_DEN:  begin w_a1 = r_mr; w_b1 = r_mr; w_a2 = r_pi; w_b2 = r_pi; w_neg2 = 1'b0; end
            OP_NRE:  begin w_a1 = r_nr; w_b1 = r_mr; w_a2 = r_ni; w_b2 = r_pi; w_neg2 = 1'b0; end
            OP_NIM:  begin w_a1 = r_ni; w_b1 = r_mr; w_a2 = r_nr; w_b2 = r_pi; w_neg2 = 1'b1; end
            default: begin w_a1 = r_xr; w_b1 = r_xr; w_a2 = r_xi; w_b2 = r_xi; w_neg2 = 1'b0; end
        endcase
    end

    rmet_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mac_go),
        .i_neg2  (w_neg2),
        .i_a1    (w_a1),
        .i_b1    (w_b1),
        .i_a2    (w_a2),
        .i_b2    (w_b2),
        .o_busy  (mac_busy),
        .o_done  (mac_done),
        .o_neg   (mac_neg),
        .o_mag   (mac_mag)
    );

    rmet_div u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_neg   (r_nre_neg),
        .i_num   (r_nre_mag),
        .i_den   (r_den),
        .o_done  (dre_done),
        .o_flt   (dre_flt),
        .o_q     (dre_q)
    );

    rmet_div u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_neg   (r_nim_neg),
        .i_num   (r_nim_mag),
        .i_den   (r_den),
        .o_done  (dim_done),
        .o_flt   (dim_flt),
        .o_q     (dim_q)
    );

    // truncate a product sum by the fraction bits, toward zero
    assign w_sc_flt = |mac_mag[MAG_W-1:103];
    assign w_sc_mag = {1'b0, mac_mag[102:FRAC_BITS]};
    assign w_sc_val = mac_neg ? (64'sd0 - t_fix'(w_sc_mag)) : t_fix'(w_sc_mag);

    // numerator and denominator differences with overflow check
    assign w_dnr     = {r_pr[FIX_W-1], r_pr} - {r_ar[FIX_W-1], r_ar};
    assign w_dni     = {r_pi[FIX_W-1], r_pi} - {r_ai[FIX_W-1], r_ai};
    assign w_dmr     = {r_pr[FIX_W-1], r_pr} - {ONE_FIX[FIX_W-1], ONE_FIX};
    assign w_sub_ovf = (w_dnr[FIX_W] ^ w_dnr[FIX_W-1]) | (w_dni[FIX_W] ^ w_dni[FIX_W-1])
                     | (w_dmr[FIX_W] ^ w_dmr[FIX_W-1]);

    // step fault flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flt <= 1'b0;
        end else if (i_cmd.init_p) begin
            r_flt <= 1'b0;
        end else begin
            if (mac_done && (r_op == OP_CRE || r_op == OP_CIM) && w_sc_flt) begin
                r_flt <= 1'b1;
            end
            if (mac_done && r_op == OP_DEN && mac_mag == '0) begin
                r_flt <= 1'b1;
            end
            if (i_cmd.sub_go && w_sub_ovf) begin
                r_flt <= 1'b1;
            end
            if (dre_done && (dre_flt || dim_flt)) begin
                r_flt <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ar <= {{20{i_point_re[31]}}, i_point_re, 12'd0};
            r_ai <= {{20{i_point_im[31]}}, i_point_im, 12'd0};
            r_xr <= {{20{i_point_re[31]}}, i_point_re, 12'd0};
            r_xi <= {{20{i_point_im[31]}}, i_point_im, 12'd0};
        end
        if (i_cmd.upd_x) begin
            r_xr <= r_flt ? SAT_RE : dre_q;
            r_xi <= r_flt ? SAT_IM : dim_q;
        end
        if (i_cmd.mac_go) begin
            r_op <= i_cmd.mac_op;
        end
        if (i_cmd.init_p) begin
            r_pr <= r_xr;
            r_pi <= r_xi;
        end
        if (i_cmd.sub_go) begin
            r_nr <= w_dnr[FIX_W-1:0];
            r_ni <= w_dni[FIX_W-1:0];
            r_mr <= w_dmr[FIX_W-1:0];
        end
        if (mac_done) begin
            case (r_op)
                OP_CRE: r_tmp <= w_sc_val;
                OP_CIM: begin
                    r_pr <= r_tmp;
                    r_pi <= w_sc_val;
                end
                OP_DEN: r_den <= mac_mag;
                OP_NRE: begin
                    r_nre_neg <= mac_neg;
                    r_nre_mag <= mac_mag;
                end
                OP_NIM: begin
                    r_nim_neg <= mac_neg;
                    r_nim_mag <= mac_mag;
                end
                default: ;
            endcase
        end
    end

    assign o_sts.mac_done = mac_done;
    assign o_sts.mac_busy = mac_busy;
    assign o_sts.div_done = dre_done & dim_done;
    assign o_sts.norm_ge  = (mac_mag >= {41'd0, i_escape_limit, 80'd0});
    assign o_sts.flt      = r_flt;
    assign o_sts.xi_pos   = !r_xi[FIX_W-1] && (r_xi != '0);

endmodule

FILE: hw/rtl/rmet_ctrl.sv
module rmet_ctrl import rmet_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CODE_W-1:0] o_code,
    input  logic [2:0]        i_degree,
    input  logic [7:0]        i_iter_lim,
    output t_dp_cmd           o_cmd,
    input  t_dp_sts           i_sts
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_NORM = 4'd2;
    localparam logic [3:0] S_POW  = 4'd3;
    localparam logic [3:0] S_CRE  = 4'd4;
    localparam logic [3:0] S_CIM  = 4'd5;
    localparam logic [3:0] S_FCHK = 4'd6;
    localparam logic [3:0] S_SUB  = 4'd7;
    localparam logic [3:0] S_SUB2 = 4'd8;
    localparam logic [3:0] S_DEN  = 4'd9;
    localparam logic [3:0] S_NRE  = 4'd10;
    localparam logic [3:0] S_NIM  = 4'd11;
    localparam logic [3:0] S_DCHK = 4'd12;
    localparam logic [3:0] S_DIV  = 4'd13;
    localparam logic [3:0] S_UPD  = 4'd14;
    localparam logic [3:0] S_FIN  = 4'd15;

    logic [3:0]        r_state, n_state;
    logic [7:0]        r_iter, n_iter;
    logic [2:0]        r_j, n_j;
    logic              r_ovld;
    logic [CODE_W-1:0] r_code;
    t_dp_cmd           w_cmd;
    logic              w_fin_take;
    logic [CODE_W-1:0] w_code;

    assign w_fin_take = (r_state == S_FIN) && (!r_ovld || i_out_ready);

    // result code
    always_comb begin
        if (r_iter >= i_iter_lim) begin
            w_code = CODE_BOUNDED;
        end else if (i_sts.xi_pos) begin
            w_code = {2'd0, r_iter, 1'b0};
        end else begin
            w_code = {2'd0, r_iter, 1'b0} + LOWER_OFFSET;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_j     = r_j;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_iter     = 8'd0;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (r_iter >= i_iter_lim) begin
                    n_state = S_FIN;
                end else begin
                    w_cmd.mac_go = 1'b1;
                    w_cmd.mac_op = OP_NORM;
                    n_state      = S_NORM;
                end
            end
            S_NORM: begin
                if (i_sts.mac_done) begin
                    if (i_sts.norm_ge) begin
                        n_state = S_FIN;
                    end else begin
                        w_cmd.init_p = 1'b1;
                        n_j          = 3'd1;
                        n_state      = S_POW;
                    end
                end
            end
            S_POW: begin
                if (r_j >= i_degree) begin
                    n_state = S_SUB;
                end else begin
                    w_cmd.mac_go = 1'b1;
                    w_cmd.mac_op = OP_CRE;
                    n_state      = S_CRE;
                end
            end
            S_CRE: begin
                if (i_sts.mac_done) begin
                    w_cmd.mac_go = 1'b1;
                    w_cmd.mac_op = OP_CIM;
                    n_state      = S_CIM;
                end
            end
            S_CIM: begin
                if (i_sts.mac_done) begin
                    n_j     = r_j + 3'd1;
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                n_state = i_sts.flt ? S_UPD : S_POW;
            end
            S_SUB: begin
                w_cmd.sub_go = 1'b1;
                n_state      = S_SUB2;
            end
            S_SUB2: begin
                if (i_sts.flt) begin
                    n_state = S_UPD;
                end else begin
                    w_cmd.mac_go = 1'b1;
                    w_cmd.mac_op = OP_DEN;
                    n_state      = S_DEN;
                end
            end
            S_DEN: begin
                if (i_sts.mac_done) begin
                    w_cmd.mac_go = 1'b1;
                    w_cmd.mac_op = OP_NRE;
                    n_state      = S_NRE;
                end
            end
            S_NRE: begin
                if (i_sts.mac_done) begin
                    w_cmd.mac_go = 1'b1;
                    w_cmd.mac_op = OP_NIM;
                    n_state      = S_NIM;
                end
            end
            S_NIM: begin
                if (i_sts.mac_done) begin
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                if (i_sts.flt) begin
                    n_state = S_UPD;
                end else begin
                    w_cmd.div_go = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                w_cmd.upd_x = 1'b1;
                n_iter      = r_iter + 8'd1;
                n_state     = S_CHK;
            end
            S_FIN: begin
                if (w_fin_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= 8'd0;
            r_j     <= 3'd0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_j     <= n_j;
            if (r_ovld && i_out_ready) begin
                r_ovld <= 1'b0;
            end
            if (w_fin_take) begin
                r_ovld <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_fin_take) begin
            r_code <= w_code;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_code      = r_code;
    assign o_cmd       = w_cmd;

`ifndef SYNTHESIS
    a_norm_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_iter < i_iter_lim))
        else $error("magnitude check past iteration limit");
    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_take |=> r_ovld)
        else $error("finished result not registered");
    a_div_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_go |-> !i_sts.flt)
        else $error("division started on a faulted step");
`endif

endmodule
